// ----- hdl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg: shared constants for the modular exponentiation block
// Default operand width and the reset value of the modulus register.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 31;

   localparam logic [30:0] MODULUS_RESET = 31'h7FFF_FFFF;

endpackage

// ----- hdl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ exponent mod modulus
// Right-to-left binary square-and-multiply over one serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_ carries base and exponent; one response
// transaction on rsp_ returns residue. The modulus is written through csr_wr_en
// and csr_wr_data; the user must write it only while no request is in
// progress, which the block itself does not enforce. It resets to 2^31 - 1.
// The block takes one request at a time and holds req_ready low until the
// response has been taken. With W = OPERAND_WIDTH, the base is first reduced,
// then each of the W exponent bits is scanned; a bit of one multiplies the
// square into the accumulator, and the square is squared for every bit. Each
// step runs on the bit-serial multiplier, which retires one multiplier bit
// per cycle.
// A result waits in the output register while rsp_ready is low; a stalled
// receiver simply delays the return to idle. Reset abandons any request in
// progress and restores the modulus to its reset value. A modulus of zero
// yields a residue of zero.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPERAND_WIDTH-1:0] req_base,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OPERAND_WIDTH-1:0] rsp_residue,
   input  logic                     csr_wr_en,
   input  logic [OPERAND_WIDTH-1:0] csr_wr_data
);
   import mexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int IDX_W = $clog2(W + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_SCAN,
      S_ACC,
      S_SQR,
      S_RESULT
   } state_type;

   state_type        state_ff;
   logic [W-1:0]     modulus_ff;
   logic [W-1:0]     exp_ff;
   logic [W-1:0]     acc_ff;
   logic [W-1:0]     sq_ff;
   logic [W-1:0]     residue_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             mul_start_ff;
   logic [W-1:0]     mul_x_ff;
   logic [W-1:0]     mul_y_ff;

   logic         mul_done;
   logic [W-1:0] mul_product;
   logic [W-1:0] one_mod;

   // One reduced by the modulus: zero only for a modulus of one.
   assign one_mod = (modulus_ff == W'(1)) ? '0 : W'(1);

   mexp_modmul #(
      .OPERAND_WIDTH(W)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .x       (mul_x_ff),
      .y       (mul_y_ff),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[W-1:0];
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  // The base is reduced by multiplying it by one.
                  exp_ff       <= req_exponent;
                  acc_ff       <= one_mod;
                  idx_ff       <= '0;
                  mul_x_ff     <= one_mod;
                  mul_y_ff     <= req_base;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_REDUCE;
               end
            end
            S_REDUCE: begin
               if (mul_done) begin
                  sq_ff    <= mul_product;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (idx_ff == IDX_W'(W)) begin
                  residue_ff <= (modulus_ff == '0) ? '0 : acc_ff;
                  state_ff   <= S_RESULT;
               end else if (exp_ff[0]) begin
                  mul_x_ff     <= acc_ff;
                  mul_y_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_ACC;
               end else begin
                  mul_x_ff     <= sq_ff;
                  mul_y_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQR;
               end
            end
            S_ACC: begin
               if (mul_done) begin
                  acc_ff       <= mul_product;
                  mul_x_ff     <= sq_ff;
                  mul_y_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQR;
               end
            end
            S_SQR: begin
               if (mul_done) begin
                  sq_ff    <= mul_product;
                  exp_ff   <= {1'b0, exp_ff[W-1:1]};
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_RESULT: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESULT);
   assign rsp_residue = residue_ff;

endmodule

// ----- hdl/mexp_modmul.sv -----
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier
// Computes (x * y) mod modulus by interleaved shift-and-add, one bit of y per
// cycle, most significant bit first. x must already be below the modulus.
// ----------------------------------------------------------------------------
module mexp_modmul #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] x,
   input  logic [OPERAND_WIDTH-1:0] y,
   input  logic [OPERAND_WIDTH-1:0] modulus,
   output logic                     done,
   output logic [OPERAND_WIDTH-1:0] product
);
   import mexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [W-1:0]     r_ff, r_in;
   logic [W-1:0]     x_ff;
   logic [W-1:0]     y_ff;

   logic [W+1:0] t, t_m1, t_m2, m1, m2, addend;

   // With r and x both below the modulus, 2r + x stays below three times the
   // modulus, so at most two multiples have to be taken away.
   always_comb begin
      addend = y_ff[W-1] ? {2'b00, x_ff} : '0;
      t      = {1'b0, r_ff, 1'b0} + addend;
      m1     = {2'b00, modulus};
      m2     = {1'b0, modulus, 1'b0};
      t_m1   = t - m1;
      t_m2   = t - m2;
      if (t >= m2) begin
         r_in = t_m2[W-1:0];
      end else if (t >= m1) begin
         r_in = t_m1[W-1:0];
      end else begin
         r_in = t[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff <= '0;
         x_ff <= x;
         y_ff <= y;
      end else if (busy_ff) begin
         r_ff <= r_in;
         y_ff <= {y_ff[W-2:0], 1'b0};
      end
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for modular_exponentiation
// Drives base/exponent requests under several moduli, with random idling on
// both channels, and compares each residue with a square-and-multiply model.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mexp_pkg::*;

   localparam int W            = OPERAND_WIDTH_DEFAULT;
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 2100;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 34;

   typedef logic [W-1:0] operand_type;

   localparam operand_type ALL_ONES = '1;

   class scoreboard_type;
      operand_type modulus;
      operand_type pending[$];
      int unsigned errors;

      function new();
         modulus = MODULUS_RESET;
         errors  = 0;
      endfunction

      function void set_modulus(operand_type value);
         modulus = value;
      endfunction

      // Right-to-left square-and-multiply; every product fits in 62 bits.
      function operand_type power_mod(operand_type b, operand_type e);
         logic [63:0] m;
         logic [63:0] acc;
         logic [63:0] sq;
         int          i;
         m = 64'(modulus);
         if (m == 0)
            return '0;
         acc = 64'd1 % m;
         sq  = 64'(b) % m;
         for (i = 0; i < W; i++) begin
            if (e[i])
               acc = (acc * sq) % m;
            sq = (sq * sq) % m;
         end
         return acc[W-1:0];
      endfunction

      function void note_request(operand_type b, operand_type e);
         pending.push_back(power_mod(b, e));
      endfunction

      task check_response(operand_type residue);
         operand_type want;
         if (pending.size() == 0) begin
            report($sformatf("residue %0d arrived with nothing outstanding", residue));
         end else begin
            want = pending.pop_front();
            if (residue !== want)
               report($sformatf("residue %0d, expected %0d (modulus %0d)",
                                residue, want, modulus));
         end
      endtask

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask
   endclass

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   operand_type req_base     = '0;
   operand_type req_exponent = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b1;
   operand_type rsp_residue;
   logic        csr_wr_en    = 1'b0;
   operand_type csr_wr_data  = '0;

   logic           idle_enable = 1'b0;
   int             stall_left  = 0;
   int             quiet       = 0;
   scoreboard_type sb          = new();

   modular_exponentiation #(
      .OPERAND_WIDTH(W)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_residue  (rsp_residue),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Observe every transaction at the edge where it completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.set_modulus(csr_wr_data);
         if (req_valid && req_ready)
            sb.note_request(req_base, req_exponent);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_residue);
      end
   end

   // Receiver back-pressure in random bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0)
            rsp_ready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 16);
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $time, quiet);
         $display("simulation failed");
         $finish;
      end
   end

   // Valid is left high after acceptance so that back-to-back requests never
   // lower and raise it within one time step.
   task automatic send_request(input operand_type b, input operand_type e);
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_base     <= b;
      req_exponent <= e;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The first edge lets the monitor record the last request before the
   // outstanding count is trusted.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_modulus(input operand_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      operand_type m;
      operand_type b;
      operand_type e;
      int          p;
      int          k;

      repeat (7) @(posedge clock);
      reset       <= 1'b0;
      idle_enable <= 1'b1;
      @(posedge clock);

      // Modulus left at its reset value, the largest 31-bit prime.
      send_request('0, '0);
      send_request('0, 31'd1);
      send_request(31'd1, ALL_ONES);
      send_request(ALL_ONES, ALL_ONES);
      send_request(ALL_ONES - 31'd1, 31'd2);
      send_request(31'd2, 31'd30);
      send_request(31'd2, 31'd31);
      send_request(31'h5555_5555, 31'h2AAA_AAAA);
      send_request(31'h2AAA_AAAA, 31'h5555_5555);
      send_request(31'd12345, 31'd1);
      send_request(ALL_ONES - 31'd1, ALL_ONES - 31'd1);
      settle();

      write_modulus(31'd2);
      send_request(ALL_ONES, ALL_ONES);
      send_request(31'd2, 31'd5);
      send_request(31'd3, '0);
      settle();

      // A base well above the modulus is reduced before the first squaring.
      write_modulus(31'd13);
      send_request(31'd100, 31'd7);
      send_request(31'd13, 31'd3);
      settle();

      // A modulus of one or zero gives a residue of zero throughout.
      write_modulus(31'd1);
      send_request(31'd5, 31'd3);
      send_request('0, '0);
      settle();

      write_modulus('0);
      send_request(31'd7, 31'd9);
      send_request(ALL_ONES, '0);
      settle();

      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0:       m = operand_type'($urandom_range(2, 32'h7FFF_FFFF));
            1:       m = operand_type'($urandom_range(2, 1000));
            2:       m = ALL_ONES;
            default: m = operand_type'($urandom) | 31'h4000_0000;
         endcase
         write_modulus(m);
         // The final phase runs with no idling on either side.
         idle_enable <= (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(0, 9))
               0:       b = '0;
               1:       b = 31'd1;
               2:       b = m - 31'd1;
               3:       b = m;
               4:       b = ALL_ONES;
               default: b = operand_type'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0:       e = '0;
               1:       e = ALL_ONES;
               2, 3:    e = operand_type'($urandom_range(0, 64));
               default: e = operand_type'($urandom);
            endcase
            send_request(b, e);
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
